[src/slpf_pkg.sv]
// Shared constants and types for the sub-board line parser and framer.
package slpf_pkg;

    // Line and idle timing
    localparam int LINE_CHARS  = 15;
    localparam int IDLE_PERIOD = 42;
    localparam int POS_W       = $clog2(LINE_CHARS + 1);
    localparam int IDLE_W      = $clog2(IDLE_PERIOD + 1);

    // Register map, index is paddr[3:2]
    localparam logic [1:0] REG_MODEL_FAN   = 2'd0;
    localparam logic [1:0] REG_FAN_RATE    = 2'd1;
    localparam logic [1:0] REG_TARGET_TEMP = 2'd2;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_P     = 8'h70;

    // Frame constants
    localparam logic [7:0]  SYNC0       = 8'h55;
    localparam logic [7:0]  SYNC1       = 8'hAA;
    localparam logic [15:0] TEMP_OFFSET = 16'd512;
    localparam logic [2:0]  FRAME_LAST  = 3'd4;

    // Slot rotation
    localparam logic [1:0] SLOT_MODEL_FAN = 2'd0;
    localparam logic [1:0] SLOT_EXTR_FAN  = 2'd1;
    localparam logic [1:0] SLOT_TARGET    = 2'd2;

    // Extruder fan rule
    localparam logic signed [15:0] FAN_HIGH_LIMIT = 16'sd200;
    localparam logic signed [15:0] FAN_LOW_LIMIT  = 16'sd70;
    localparam logic [7:0]         FAN_HIGH_DUTY  = 8'd220;
    localparam logic [7:0]         FAN_LOW_DUTY   = 8'd60;

    // Accumulator saturation
    localparam logic [15:0] ACC_MAX = 16'd32768;
    localparam logic [15:0] POS_MAX = 16'd32767;

    // Number parser phases
    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

endpackage

[src/subboard_line_parser_and_framer.sv]
// Top level: line parser, idle tick counter, status frame builder and APB registers.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  input    | in        | in_valid / in_ready   | kind, rx_byte
//  output   | out       | out_valid / out_ready | tx_byte, last_byte, temperature,
//           |           |                       | pressure, line_count
//  config   | in        | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// Each input beat is handled in the cycle it is accepted; state updates at that edge.
// A beat that starts a frame loads five output beats into the frame shift register;
// they drain one per cycle while out_ready is high; the next frame waits for them.
// Beats that cause no frame are accepted every cycle, also while a frame drains.
// Reset clears all control state and the registers to their reset values.
// Output stalls hold the frame; an input beat that would start a frame waits for it.
module subboard_line_parser_and_framer
    import slpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         tx_byte,
    output logic               last_byte,
    output logic signed [15:0] temperature,
    output logic signed [15:0] pressure,
    output logic [15:0]        line_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Configuration registers
    logic [7:0]  model_fan_reg;
    logic [9:0]  fan_rate_reg;
    logic [15:0] target_temp_reg;

    // Parser and framer state
    logic [1:0]        slot_reg,      slot_next;
    logic [IDLE_W-1:0] idle_reg,      idle_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [7:0]        line_kind_reg, line_kind_next;
    phase_t            phase_reg,     phase_next;
    logic              neg_reg,       neg_next;
    logic [15:0]       acc_reg,       acc_next;
    logic [15:0]       temp_reg,      temp_next;
    logic [15:0]       press_reg,     press_next;
    logic [7:0]        extr_fan_reg,  extr_fan_next;
    logic [15:0]       line_cnt_reg,  line_cnt_next;

    // Frame output buffer
    logic [7:0]  frame_reg [5];
    logic [2:0]  beat_reg;
    logic        busy_reg;
    logic [15:0] snap_temp_reg;
    logic [15:0] snap_press_reg;
    logic [15:0] snap_cnt_reg;

    logic cfg_write;
    logic in_fire;
    logic out_done;
    logic tick_frame;
    logic line_frame;
    logic emit;

    logic [IDLE_W:0] idle_inc;
    logic            is_blank;
    logic            is_digit;
    logic [18:0]     acc_calc;
    logic [15:0]     acc_digit;
    logic [15:0]     parsed;
    logic signed [15:0] parsed_s;

    logic [7:0]  fan_sel;
    logic [17:0] fan_prod;
    logic [7:0]  fan_scaled;
    logic [15:0] target_ofs;
    logic [7:0]  pay0;
    logic [7:0]  pay1;
    logic [7:0]  csum;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODEL_FAN:   prdata = {24'd0, model_fan_reg};
            REG_FAN_RATE:    prdata = {22'd0, fan_rate_reg};
            REG_TARGET_TEMP: prdata = {16'd0, target_temp_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_fan_reg   <= 8'd0;
            fan_rate_reg    <= 10'd256;
            target_temp_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_MODEL_FAN:   model_fan_reg   <= pwdata[7:0];
                REG_FAN_RATE:    fan_rate_reg    <= pwdata[9:0];
                REG_TARGET_TEMP: target_temp_reg <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    // Decide whether this beat starts a frame
    assign idle_inc   = {1'b0, idle_reg} + 1'b1;
    assign tick_frame = kind && (idle_inc >= (IDLE_W + 1)'(IDLE_PERIOD));
    assign line_frame = !kind && (rx_byte == CH_CR) && (pos_reg != '0)
                        && (line_kind_reg == CH_T);

    // Hold frame-causing beats while the previous frame drains
    assign out_done = busy_reg && out_ready && (beat_reg == FRAME_LAST);
    assign in_ready = !busy_reg || out_done || !(tick_frame || line_frame);
    assign in_fire  = in_valid && in_ready;
    assign emit     = in_fire && (tick_frame || line_frame);

    // Character classes and digit accumulation
    assign is_blank  = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB)
                       || (rx_byte == CH_VT) || (rx_byte == CH_FF);
    assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign acc_calc  = 19'(acc_reg) * 19'd10 + 19'(rx_byte[3:0]);
    assign acc_digit = (acc_calc > 19'(ACC_MAX)) ? ACC_MAX : acc_calc[15:0];

    // Value of the finished line
    assign parsed   = neg_reg ? (16'd0 - acc_reg)
                              : ((acc_reg > POS_MAX) ? POS_MAX : acc_reg);
    assign parsed_s = parsed;

    // Frame payload from the current slot
    assign fan_sel    = (slot_reg == SLOT_MODEL_FAN) ? model_fan_reg : extr_fan_reg;
    assign fan_prod   = 18'(fan_sel) * 18'(fan_rate_reg);
    assign fan_scaled = (fan_prod[17:8] > 10'd255) ? 8'hFF : fan_prod[15:8];
    assign target_ofs = target_temp_reg + TEMP_OFFSET;

    always_comb
    begin
        unique case (slot_reg)
            SLOT_MODEL_FAN:
            begin
                pay0 = 8'd0;
                pay1 = fan_scaled;
            end
            SLOT_EXTR_FAN:
            begin
                pay0 = 8'd1;
                pay1 = fan_scaled;
            end
            default:
            begin
                pay0 = target_ofs[15:8];
                pay1 = target_ofs[7:0];
            end
        endcase
    end

    assign csum = 8'd0 - pay0 - pay1;

    // Next state for one accepted beat
    always_comb
    begin
        slot_next      = slot_reg;
        idle_next      = idle_reg;
        pos_next       = pos_reg;
        line_kind_next = line_kind_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        temp_next      = temp_reg;
        press_next     = press_reg;
        extr_fan_next  = extr_fan_reg;
        line_cnt_next  = line_cnt_reg;

        if (emit)
        begin
            slot_next = (slot_reg >= SLOT_TARGET) ? SLOT_MODEL_FAN : slot_reg + 2'd1;
        end

        if (in_fire && kind)
        begin
            // Idle tick: count, restart on frame
            idle_next = tick_frame ? '0 : idle_inc[IDLE_W-1:0];
        end
        else if (in_fire && (rx_byte == CH_LF || rx_byte == CH_NUL))
        begin
            // Drop newline and NUL
        end
        else if (in_fire && rx_byte == CH_CR)
        begin
            // End of line: store value, clear the line
            pos_next       = '0;
            line_kind_next = 8'd0;
            phase_next     = PH_SKIP;
            neg_next       = 1'b0;
            acc_next       = 16'd0;
            if (line_frame)
            begin
                temp_next     = parsed;
                line_cnt_next = line_cnt_reg + 16'd1;
                if (parsed_s > FAN_HIGH_LIMIT)
                    extr_fan_next = FAN_HIGH_DUTY;
                else if (parsed_s > FAN_LOW_LIMIT)
                    extr_fan_next = parsed[7:0];
                else
                    extr_fan_next = FAN_LOW_DUTY;
            end
            else if (pos_reg != '0 && line_kind_reg == CH_P)
            begin
                press_next = parsed;
            end
        end
        else if (in_fire)
        begin
            // Ordinary character: kind byte, then number characters
            if (pos_reg == '0)
            begin
                line_kind_next = rx_byte;
            end
            else if (pos_reg < POS_W'(LINE_CHARS))
            begin
                unique case (phase_reg)
                    PH_SKIP:
                    begin
                        if (rx_byte == CH_PLUS || rx_byte == CH_MINUS)
                        begin
                            neg_next   = (rx_byte == CH_MINUS);
                            phase_next = PH_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            acc_next   = acc_digit;
                            phase_next = PH_DIGITS;
                        end
                        else if (!is_blank)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_DIGITS:
                    begin
                        if (is_digit)
                            acc_next = acc_digit;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_DONE: ;
                    default: phase_next = PH_DONE;
                endcase
            end
            if (pos_reg < POS_W'(LINE_CHARS))
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // Advance parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= SLOT_MODEL_FAN;
            idle_reg      <= '0;
            pos_reg       <= '0;
            line_kind_reg <= 8'd0;
            phase_reg     <= PH_SKIP;
            neg_reg       <= 1'b0;
            acc_reg       <= 16'd0;
            temp_reg      <= 16'd0;
            press_reg     <= 16'd0;
            extr_fan_reg  <= 8'd0;
            line_cnt_reg  <= 16'd0;
        end
        else
        begin
            slot_reg      <= slot_next;
            idle_reg      <= idle_next;
            pos_reg       <= pos_next;
            line_kind_reg <= line_kind_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            temp_reg      <= temp_next;
            press_reg     <= press_next;
            extr_fan_reg  <= extr_fan_next;
            line_cnt_reg  <= line_cnt_next;
        end
    end

    // Frame control: load on emit, count beats out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= 3'd0;
        end
        else if (emit)
        begin
            busy_reg <= 1'b1;
            beat_reg <= 3'd0;
        end
        else if (out_done)
        begin
            busy_reg <= 1'b0;
            beat_reg <= 3'd0;
        end
        else if (busy_reg && out_ready)
        begin
            beat_reg <= beat_reg + 3'd1;
        end
    end

    // Frame payload: load bytes and snapshot, shift one byte per beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            frame_reg[0]   <= SYNC0;
            frame_reg[1]   <= SYNC1;
            frame_reg[2]   <= pay0;
            frame_reg[3]   <= pay1;
            frame_reg[4]   <= csum;
            snap_temp_reg  <= temp_next;
            snap_press_reg <= press_reg;
            snap_cnt_reg   <= line_cnt_next;
        end
        else if (busy_reg && out_ready)
        begin
            for (int i = 0; i < 4; i++)
            begin
                frame_reg[i] <= frame_reg[i + 1];
            end
        end
    end

    assign out_valid   = busy_reg;
    assign tx_byte     = frame_reg[0];
    assign last_byte   = (beat_reg == FRAME_LAST);
    assign temperature = snap_temp_reg;
    assign pressure    = snap_press_reg;
    assign line_count  = snap_cnt_reg;

    // A new frame opens with the first sync byte
    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid && tx_byte == SYNC0 && !last_byte))
        else $error("frame did not start with sync byte");

    // The second beat of a frame is the second sync byte
    a_frame_sync1: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && beat_reg == 3'd0 && !emit) |=> (tx_byte == SYNC1))
        else $error("second frame beat is not the second sync byte");

    // The line count only moves with a temperature frame
    a_count_frame: assert property (@(posedge clk) disable iff (!rst_n)
        !(emit && line_frame) |=> $stable(line_cnt_reg))
        else $error("line count changed without a temperature frame");

    // The idle counter never reaches the period
    a_idle_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, idle_reg} < (IDLE_W + 1)'(IDLE_PERIOD)))
        else $error("idle counter out of range");

endmodule

[bench/slpf_frame_checker.sv]
// Frame checker: predicts the status frames of the line parser and compares every output beat.
`timescale 1ns / 100ps

module slpf_frame_checker
    import slpf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               kind,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         tx_byte,
    input  logic               last_byte,
    input  logic signed [15:0] temperature,
    input  logic signed [15:0] pressure,
    input  logic [15:0]        line_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 outstanding
);

    typedef struct packed {
        logic [7:0]         tx;
        logic               last;
        logic signed [15:0] temp;
        logic signed [15:0] pres;
        logic [15:0]        count;
    } frame_beat_t;

    frame_beat_t expected_beats[$];
    int          fail_count = 0;
    int          pending = 0;

    // Register copies
    logic [7:0]  cfg_model_fan;
    logic [9:0]  cfg_rate;
    logic [15:0] cfg_target;

    // Predicted block state
    logic [1:0]         slot;
    logic [IDLE_W-1:0]  idle_ticks;
    logic [POS_W-1:0]   col;
    logic [7:0]         lead_char;
    phase_t             phase;
    logic               minus;
    logic [16:0]        magnitude;
    logic signed [15:0] temp_q;
    logic signed [15:0] pres_q;
    logic [7:0]         extr_fan;
    logic [15:0]        t_lines;

    assign errors      = fail_count;
    assign outstanding = pending;

    task automatic report(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Scale a fan duty by the Q2.8 rate, saturating at full scale
    function automatic logic [7:0] fan_scaled(input logic [7:0] fan);
        logic [17:0] prod;
        prod = 18'(fan) * 18'(cfg_rate);
        prod = prod >> 8;
        return (prod > 18'd255) ? 8'hFF : prod[7:0];
    endfunction

    // Signed 16-bit result of the number seen so far on the line
    function automatic logic [15:0] line_value();
        logic [16:0] neg;
        neg = 17'd0 - magnitude;
        if (minus)
        begin
            return neg[15:0];
        end
        return (magnitude > {1'b0, POS_MAX}) ? POS_MAX : magnitude[15:0];
    endfunction

    // Queue the five beats of the frame in the current slot, then advance the slot
    task automatic load_frame();
        logic [7:0]  p0;
        logic [7:0]  p1;
        logic [15:0] shifted;
        logic [7:0]  frame_bytes [5];
        frame_beat_t b;
        case (slot)
            SLOT_MODEL_FAN:
            begin
                p0 = 8'(slot);
                p1 = fan_scaled(cfg_model_fan);
            end
            SLOT_EXTR_FAN:
            begin
                p0 = 8'(slot);
                p1 = fan_scaled(extr_fan);
            end
            default:
            begin
                shifted = cfg_target + TEMP_OFFSET;
                p0 = shifted[15:8];
                p1 = shifted[7:0];
            end
        endcase
        frame_bytes[0] = SYNC0;
        frame_bytes[1] = SYNC1;
        frame_bytes[2] = p0;
        frame_bytes[3] = p1;
        frame_bytes[4] = 8'h00 - p0 - p1;
        for (int k = 0; k < 5; k++)
        begin
            b.tx    = frame_bytes[k];
            b.last  = (k == int'(FRAME_LAST));
            b.temp  = temp_q;
            b.pres  = pres_q;
            b.count = t_lines;
            expected_beats.push_back(b);
        end
        slot = (slot == SLOT_TARGET) ? SLOT_MODEL_FAN : slot + 2'd1;
    endtask

    // Feed one character at a numeric position to the atoi-style parser
    task automatic parse_char(input logic [7:0] c);
        logic is_digit;
        int   acc;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (phase == PH_SKIP)
        begin
            if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
            begin
                return;
            end
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                minus = (c == CH_MINUS);
                phase = PH_DIGITS;
                return;
            end
            phase = is_digit ? PH_DIGITS : PH_DONE;
        end
        if (phase == PH_DIGITS)
        begin
            if (is_digit)
            begin
                acc = int'(magnitude) * 10 + int'(c) - int'(CH_ZERO);
                magnitude = (acc > int'(ACC_MAX)) ? 17'(ACC_MAX) : 17'(acc);
            end
            else
            begin
                phase = PH_DONE;
            end
        end
    endtask

    // Advance the predicted state by one accepted input beat
    task automatic predict_item(input logic is_tick, input logic [7:0] c);
        logic               had;
        logic [7:0]         lead;
        logic signed [15:0] v;
        if (is_tick)
        begin
            if (int'(idle_ticks) + 1 >= IDLE_PERIOD)
            begin
                idle_ticks = '0;
                load_frame();
            end
            else
            begin
                idle_ticks = idle_ticks + 1'b1;
            end
            return;
        end
        if (c == CH_LF || c == CH_NUL)
        begin
            return;
        end
        if (c == CH_CR)
        begin
            had       = (col != 0);
            lead      = lead_char;
            v         = line_value();
            col       = '0;
            lead_char = 8'h00;
            phase     = PH_SKIP;
            minus     = 1'b0;
            magnitude = '0;
            if (had && lead == CH_T)
            begin
                temp_q  = v;
                t_lines = t_lines + 16'd1;
                load_frame();
                // fan rule takes effect only for later frames, not the one just loaded
                if (v > FAN_HIGH_LIMIT)
                begin
                    extr_fan = FAN_HIGH_DUTY;
                end
                else if (v > FAN_LOW_LIMIT)
                begin
                    extr_fan = v[7:0];
                end
                else
                begin
                    extr_fan = FAN_LOW_DUTY;
                end
            end
            else if (had && lead == CH_P)
            begin
                pres_q = v;
            end
            return;
        end
        if (col == 0)
        begin
            lead_char = c;
        end
        else if (col < LINE_CHARS)
        begin
            parse_char(c);
        end
        if (col < LINE_CHARS)
        begin
            col = col + 1'b1;
        end
    endtask

    // Compare one output beat against the oldest expectation
    task automatic check_beat();
        frame_beat_t want;
        if (expected_beats.size() == 0)
        begin
            report("unexpected beat, tx_byte", tx_byte, -1);
            return;
        end
        want = expected_beats.pop_front();
        if (tx_byte !== want.tx)
        begin
            report("tx_byte", tx_byte, want.tx);
        end
        if (last_byte !== want.last)
        begin
            report("last_byte", last_byte, want.last);
        end
        if (temperature !== want.temp)
        begin
            report("temperature", temperature, want.temp);
        end
        if (pressure !== want.pres)
        begin
            report("pressure", pressure, want.pres);
        end
        if (line_count !== want.count)
        begin
            report("line_count", line_count, want.count);
        end
    endtask

    // Watch the three ports at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_model_fan = 8'd0;
            cfg_rate      = 10'd256;
            cfg_target    = 16'd0;
            slot          = SLOT_MODEL_FAN;
            idle_ticks    = '0;
            col           = '0;
            lead_char     = 8'h00;
            phase         = PH_SKIP;
            minus         = 1'b0;
            magnitude     = '0;
            temp_q        = '0;
            pres_q        = '0;
            extr_fan      = 8'd0;
            t_lines       = 16'd0;
            expected_beats.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_beat();
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MODEL_FAN:   cfg_model_fan = pwdata[7:0];
                    REG_FAN_RATE:    cfg_rate      = pwdata[9:0];
                    REG_TARGET_TEMP: cfg_target    = pwdata[15:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_item(kind, rx_byte);
            end
            pending <= expected_beats.size();
        end
    end

endmodule

[bench/subboard_line_parser_and_framer_tb.sv]
// Testbench top: drives lines, idle ticks and register writes into the parser and gives the verdict.
`timescale 1ns / 100ps

module subboard_line_parser_and_framer_tb
    import slpf_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = 1'b0;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         tx_byte;
    logic               last_byte;
    logic signed [15:0] temperature;
    logic signed [15:0] pressure;
    logic [15:0]        line_count;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = 4'd0;
    logic [31:0]        pwdata = 32'd0;
    logic [31:0]        prdata;
    logic               pready;

    int errors;
    int outstanding;
    int sent_count = 0;
    int beats_taken = 0;
    int quiet_cycles = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;
    bit held = 1'b0;

    subboard_line_parser_and_framer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .temperature (temperature),
        .pressure    (pressure),
        .line_count  (line_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    slpf_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_byte     (tx_byte),
        .last_byte   (last_byte),
        .temperature (temperature),
        .pressure    (pressure),
        .line_count  (line_count),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: abort when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one input beat after a random gap and hold it until taken
    task automatic send_item(input logic is_tick, input logic [7:0] c);
        int gap;
        if (sent_count % 16 == 0)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
        end
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= is_tick;
        rx_byte  <= c;
        do @(posedge clk); while (!in_ready);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(1'b0, s[i]);
        end
    endtask

    // Drop valid and hold off until every expected beat has come out
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [7:0] fan, input logic [9:0] rate,
                            input logic [15:0] target);
        write_reg(REG_MODEL_FAN, {24'd0, fan});
        write_reg(REG_FAN_RATE, {22'd0, rate});
        write_reg(REG_TARGET_TEMP, {16'd0, target});
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    // Send one line; style 0 is well formed, 1 pushes digits past the line end,
    // 2 carries a stray character somewhere in the body
    task automatic send_random_line(input int style);
        logic [7:0] body[$];
        logic [7:0] lead;
        string      digits;
        int         mag;
        int         r;
        r = $urandom_range(0, 9);
        lead = (r < 5) ? CH_T : (r < 8) ? CH_P : 8'($urandom_range(0, 255));
        repeat ((style == 1) ? $urandom_range(10, 16) : $urandom_range(0, 2))
        begin
            body.push_back(pick_blank());
        end
        r = $urandom_range(0, 3);
        if (r == 1)
        begin
            body.push_back(CH_PLUS);
        end
        else if (r == 2)
        begin
            body.push_back(CH_MINUS);
        end
        case ($urandom_range(0, 3))
            0:       mag = $urandom_range(0, 300);
            1:       mag = $urandom_range(60, 210);
            2:       mag = $urandom_range(0, 99999);
            default: mag = 32766 + $urandom_range(0, 3);
        endcase
        digits = ($urandom_range(0, 19) == 0) ? "" : $sformatf("%0d", mag);
        if ($urandom_range(0, 7) == 0)
        begin
            digits = {"00", digits};
        end
        for (int i = 0; i < digits.len(); i++)
        begin
            body.push_back(digits[i]);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            body.push_back(8'($urandom_range(32, 126)));
            body.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (style == 2)
        begin
            r = $urandom_range(0, 2);
            body.insert($urandom_range(0, body.size()),
                        (r == 0) ? CH_LF : (r == 1) ? CH_NUL : 8'($urandom_range(32, 126)));
        end
        send_item(1'b0, lead);
        foreach (body[i])
        begin
            send_item(1'b0, body[i]);
        end
        send_item(1'b0, CH_CR);
    endtask

    // One random chunk of traffic: mostly lines, some tick runs and raw noise
    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
        begin
            send_random_line(0);
        end
        else if (pick < 7)
        begin
            repeat ($urandom_range(1, 30)) send_item(1'b1, 8'($urandom_range(0, 255)));
        end
        else if (pick == 7)
        begin
            repeat ($urandom_range(1, 4))
            begin
                send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            send_random_line(pick - 7);
        end
    endtask

    // Result side: random stalls, calm stretches and one long hold-off
    initial
    begin
        int gap;
        forever
        begin
            if (beats_taken % 16 == 0)
            begin
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            if (!held && beats_taken >= 40)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = rx_calm ? 0 : $urandom_range(0, 14);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            beats_taken++;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int quota;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: saturation, blanks and sign, dropped bytes, empty and foreign lines
        send_text("t99999");
        send_item(1'b0, CH_CR);
        send_text("p\t-5");
        send_item(1'b0, CH_NUL);
        send_item(1'b0, CH_CR);
        send_item(1'b0, CH_CR);
        send_text("x5");
        send_item(1'b0, CH_LF);
        send_item(1'b0, CH_CR);
        send_text("t+");
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CH_CR);
        send_item(1'b1, 8'hFF);

        // Random phases, each under its own register setting
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_quiet();
            case (ph)
                0:       set_regs(8'hFF, 10'h3FF, 16'hFFFF);
                1:       set_regs(8'h00, 10'h000, 16'h0000);
                3:       set_regs(8'd200, 10'd300, 16'd65024);
                default: set_regs(8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                                  16'($urandom_range(0, 65535)));
            endcase
            quota = sent_count + 60;
            while (sent_count < quota) send_random_chunk();
        end

        wait_quiet();
        repeat (16) @(posedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
